// ----- sv/safs_pkg.sv -----
package safs_pkg;
  localparam int unsigned FramesPerDef = 16;
  localparam int unsigned Definitions  = 8;
  localparam int unsigned Slots        = 16;
  localparam int unsigned FrameStore   = FramesPerDef * Definitions;
  localparam int unsigned FaW = $clog2(FrameStore);
  localparam int unsigned FiW = $clog2(FramesPerDef);
  localparam int unsigned DfW = $clog2(Definitions);
  localparam int unsigned SlW = $clog2(Slots);

  typedef enum logic [2:0] {
    CmdDefine  = 3'd0,
    CmdCreate  = 3'd1,
    CmdDestroy = 3'd2,
    CmdTick    = 3'd3,
    CmdGet     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBadDef = 2'd1,
    StFull   = 2'd2,
    StBadSlt = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  def_id;
    logic [3:0]  frame_index;
    logic [4:0]  frame_total;
    logic [7:0]  frame_row;
    logic [7:0]  frame_column;
    logic [15:0] frame_duration;
    logic [3:0]  slot_id;
    logic        loop_flag;
    logic [15:0] tick_delta;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [3:0]  current_frame;
    logic [7:0]  row_out;
    logic [7:0]  column_out;
    logic [16:0] time_left;
    logic        active_out;
  } out_t;

  typedef enum logic [3:0] {
    OpNone   = 4'd0,
    OpDecode = 4'd1,
    OpScan   = 4'd2,
    OpSub    = 4'd3,
    OpRead   = 4'd4,
    OpLoad   = 4'd5,
    OpGetRd  = 4'd6,
    OpGetOut = 4'd7,
    OpCreate = 4'd8
  } op_e;

  typedef struct packed {
    op_e op;
  } ctl_t;

  typedef struct packed {
    logic last_slot;
    logic found;
    logic expired;
    logic no_slots;
  } sts_t;
endpackage

// ----- sv/safs_if.sv -----
interface safs_if #(parameter int unsigned W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/safs_ram.sv -----
module safs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- sv/safs_ctrl.sv -----
module safs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  safs_pkg::sts_t      sts_i,
  output safs_pkg::ctl_t      ctl_o
);
  typedef enum logic [6:0] {
    SIdle = 7'b0000001,
    SDec  = 7'b0000010,
    SScan = 7'b0000100,
    SRead = 7'b0001000,
    SLoad = 7'b0010000,
    SGet  = 7'b0100000,
    SOut  = 7'b1000000
  } state_e;
  state_e state_q, state_d;
  logic [2:0] cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_valid_i && in_ready_o) cmd_q <= cmd_i;
    end
  end

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);

  always_comb begin
    state_d   = state_q;
    ctl_o.op  = safs_pkg::OpNone;
    case (state_q)
      SIdle: if (in_valid_i) state_d = SDec;
      SDec: begin
        ctl_o.op = safs_pkg::OpDecode;
        case (cmd_q)
          safs_pkg::CmdCreate: state_d = SScan;
          safs_pkg::CmdTick:   state_d = sts_i.no_slots ? SOut : SRead;
          safs_pkg::CmdGet:    state_d = SGet;
          default:             state_d = SOut;
        endcase
      end
      SScan: begin
        ctl_o.op = safs_pkg::OpScan;
        if (sts_i.found || sts_i.last_slot) begin
          ctl_o.op = safs_pkg::OpCreate;
          state_d  = SOut;
        end
      end
      SRead: begin
        ctl_o.op = safs_pkg::OpSub;
        state_d  = SLoad;
      end
      SLoad: begin
        ctl_o.op = safs_pkg::OpLoad;
        state_d  = sts_i.last_slot ? SOut : SRead;
      end
      SGet: begin
        ctl_o.op = safs_pkg::OpGetOut;
        state_d  = SOut;
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end
endmodule

// ----- sv/safs_dp.sv -----
module safs_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  safs_pkg::in_t  in_i,
  input  safs_pkg::ctl_t ctl_i,
  output safs_pkg::sts_t sts_o,
  output safs_pkg::out_t out_o
);
  localparam int unsigned FaW = safs_pkg::FaW;
  localparam int unsigned SlW = safs_pkg::SlW;
  localparam int unsigned DfW = safs_pkg::DfW;
  localparam int unsigned FiW = safs_pkg::FiW;

  safs_pkg::in_t  in_q;
  safs_pkg::out_t out_q;
  logic [4:0]   cnt_q [safs_pkg::Definitions];
  logic [DfW-1:0] sdef_q [safs_pkg::Slots];
  logic         sloop_q [safs_pkg::Slots];
  logic         sact_q [safs_pkg::Slots];
  logic [FiW-1:0] sfrm_q [safs_pkg::Slots];
  logic [16:0]  stim_q [safs_pkg::Slots];
  logic [SlW:0] used_q;
  logic [SlW:0] idx_q;
  logic [16:0]  tnew_q;
  logic [FiW-1:0] nxt_q;

  logic [SlW-1:0] idx;
  logic [FaW-1:0] waddr, raddr;
  logic [31:0]    rdata;
  logic           we;
  logic [4:0]     cnt_sel;
  logic [FiW:0]   nxt_w;
  logic [16:0]    tsub;
  logic           def_ok;

  assign idx    = idx_q[SlW-1:0];
  assign def_ok = ({29'd0, in_q.def_id} < 32'(safs_pkg::Definitions));
  assign we     = (ctl_i.op == safs_pkg::OpDecode) && (in_q.cmd == safs_pkg::CmdDefine)
                  && def_ok && ({28'd0, in_q.frame_index} < 32'(safs_pkg::FramesPerDef));
  assign waddr  = FaW'({in_q.def_id[DfW-1:0], in_q.frame_index[FiW-1:0]});
  assign cnt_sel = cnt_q[sdef_q[idx]];
  assign tsub   = stim_q[idx] - {1'b0, in_q.tick_delta};

  always_comb begin
    nxt_w = {1'b0, sfrm_q[idx]} + 1'b1;
    if (nxt_w >= cnt_sel) begin
      if (sloop_q[idx] || cnt_sel == 5'd0) nxt_w = '0;
      else nxt_w = (FiW+1)'(cnt_sel - 5'd1);
    end
    raddr = FaW'({sdef_q[idx], sfrm_q[idx]});
    if (ctl_i.op == safs_pkg::OpSub) raddr = FaW'({sdef_q[idx], nxt_w[FiW-1:0]});
    if (ctl_i.op == safs_pkg::OpDecode) begin
      raddr = FaW'({sdef_q[in_q.slot_id[SlW-1:0]], sfrm_q[in_q.slot_id[SlW-1:0]]});
    end
  end

  safs_ram #(.Width(32), .Depth(safs_pkg::FrameStore)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr),
    .wdata_i({in_q.frame_row, in_q.frame_column, in_q.frame_duration}),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign sts_o.no_slots  = (used_q == '0);
  assign sts_o.last_slot = (idx_q + 1'b1 >= used_q);
  assign sts_o.found     = (idx_q < used_q) && !sact_q[idx];
  assign sts_o.expired   = $signed(tsub) <= 0;
  assign out_o = out_q;

  always_ff @(posedge clk_i) begin
    if (load_i) in_q <= in_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      idx_q  <= '0;
      out_q  <= '0;
      tnew_q <= '0;
      nxt_q  <= '0;
      for (int i = 0; i < int'(safs_pkg::Definitions); i++) cnt_q[i] <= '0;
      for (int i = 0; i < int'(safs_pkg::Slots); i++) begin
        sdef_q[i] <= '0; sloop_q[i] <= 1'b0; sact_q[i] <= 1'b0;
        sfrm_q[i] <= '0; stim_q[i] <= '0;
      end
    end else begin
      case (ctl_i.op)
        safs_pkg::OpDecode: begin
          out_q  <= '0;
          idx_q  <= '0;
          case (in_q.cmd)
            safs_pkg::CmdDefine: begin
              if (!def_ok) out_q.status <= safs_pkg::StBadDef;
              else if (in_q.frame_total > 5'(safs_pkg::FramesPerDef))
                cnt_q[in_q.def_id[DfW-1:0]] <= 5'(safs_pkg::FramesPerDef);
              else cnt_q[in_q.def_id[DfW-1:0]] <= in_q.frame_total;
            end
            safs_pkg::CmdDestroy: begin
              if ({1'b0, in_q.slot_id} >= 5'(used_q)) out_q.status <= safs_pkg::StBadSlt;
              else sact_q[in_q.slot_id[SlW-1:0]] <= 1'b0;
            end
            default: ;
          endcase
        end
        safs_pkg::OpScan: idx_q <= idx_q + 1'b1;
        safs_pkg::OpCreate: begin
          if (!def_ok || cnt_q[in_q.def_id[DfW-1:0]] == 5'd0) begin
            out_q.status <= safs_pkg::StBadDef;
          end else begin : mk
            logic [SlW:0] id;
            id = sts_o.found ? idx_q : used_q;
            if (!sts_o.found && used_q >= (SlW+1)'(safs_pkg::Slots)) begin
              out_q.status <= safs_pkg::StFull;
            end else begin
              if (!sts_o.found) used_q <= used_q + 1'b1;
              sdef_q[id[SlW-1:0]]  <= in_q.def_id[DfW-1:0];
              sloop_q[id[SlW-1:0]] <= in_q.loop_flag;
              sact_q[id[SlW-1:0]]  <= 1'b1;
              sfrm_q[id[SlW-1:0]]  <= '0;
              stim_q[id[SlW-1:0]]  <= '0;
              out_q.slot_out       <= 4'(id);
            end
          end
        end
        safs_pkg::OpSub: begin
          tnew_q <= sts_o.expired ? 17'h1ffff : tsub;
          stim_q[idx] <= tsub;
          nxt_q  <= sts_o.expired ? nxt_w[FiW-1:0] : sfrm_q[idx];
        end
        safs_pkg::OpLoad: begin
          if (tnew_q == 17'h1ffff && $signed(stim_q[idx]) <= 0) begin
            sfrm_q[idx] <= nxt_q;
            stim_q[idx] <= {1'b0, rdata[15:0]};
          end
          idx_q <= idx_q + 1'b1;
        end
        safs_pkg::OpGetOut: begin
          if ({1'b0, in_q.slot_id} >= 5'(used_q)) begin
            out_q.status <= safs_pkg::StBadSlt;
          end else begin
            out_q.slot_out      <= in_q.slot_id;
            out_q.current_frame <= 4'(sfrm_q[in_q.slot_id[SlW-1:0]]);
            out_q.row_out       <= rdata[31:24];
            out_q.column_out    <= rdata[23:16];
            out_q.time_left     <= stim_q[in_q.slot_id[SlW-1:0]];
            out_q.active_out    <= sact_q[in_q.slot_id[SlW-1:0]];
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- sv/sprite_animation_frame_sequencer.sv -----
// Sprite animation frame sequencer: one command in, one result out. Define,
// destroy and unknown commands go from decode straight to the result; create
// scans the slot table one slot a cycle; tick walks every used slot
// (subtract, then frame memory read and reload). The frame table sits in one
// registered-read RAM; every slot holds its own registers. No new command is
// taken until the result has been transferred.
module sprite_animation_frame_sequencer (
  input  logic clk_i,
  input  logic rst_ni,
  safs_if.sink   in_if,
  safs_if.source out_if
);
  safs_pkg::ctl_t ctl;
  safs_pkg::sts_t sts;
  safs_pkg::out_t res;
  safs_pkg::in_t  cmd_in;
  logic ready;

  assign cmd_in = safs_pkg::in_t'(in_if.data);

  safs_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(ready), .cmd_i(cmd_in.cmd),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .ctl_o(ctl)
  );

  safs_dp u_dp (
    .clk_i, .rst_ni, .load_i(in_if.valid && ready),
    .in_i(cmd_in), .ctl_i(ctl), .sts_o(sts), .out_o(res)
  );

  assign in_if.ready = ready;
  assign out_if.data = res;
endmodule

// ----- tb/sprite_animation_frame_sequencer_tb.sv -----
module sprite_animation_frame_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold   = 300;
  localparam int unsigned DrainWait  = 60;
  localparam logic [2:0]  CmdSpareLo = 3'd5;
  localparam logic [2:0]  CmdSpareHi = 3'd7;

  logic clk_i;
  logic rst_ni;

  safs_if #(.W($bits(safs_pkg::in_t)))  cmd_if ();
  safs_if #(.W($bits(safs_pkg::out_t))) res_if ();

  sprite_animation_frame_sequencer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (cmd_if.sink),
    .out_if (res_if.source)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // predictor state
  logic [7:0]  sheet_row  [safs_pkg::FrameStore];
  logic [7:0]  sheet_col  [safs_pkg::FrameStore];
  logic [15:0] frame_ticks[safs_pkg::FrameStore];
  logic [4:0]  def_len    [safs_pkg::Definitions];
  logic [2:0]  anim_def   [safs_pkg::Slots];
  logic        anim_loop  [safs_pkg::Slots];
  logic        anim_live  [safs_pkg::Slots];
  logic [3:0]  anim_frame [safs_pkg::Slots];
  int          anim_ticks [safs_pkg::Slots];
  int unsigned anims_used;

  safs_pkg::out_t results_due[$];
  int unsigned errors;
  int unsigned cycles;
  bit          quiet;
  bit          hold_request;
  bit          hold_done;
  int unsigned stall_left;

  function automatic int unsigned sheet_addr(logic [2:0] d, logic [3:0] f);
    return d * safs_pkg::FramesPerDef + f;
  endfunction

  function automatic void age_anim(int unsigned s, int dt);
    int unsigned cnt;
    int unsigned nxt;
    cnt = def_len[anim_def[s]];
    anim_ticks[s] -= dt;
    if (anim_ticks[s] > 0) return;
    nxt = anim_frame[s] + 1;
    if (nxt >= cnt) nxt = (anim_loop[s] || cnt == 0) ? 0 : cnt - 1;
    anim_frame[s] = nxt[3:0];
    anim_ticks[s] = frame_ticks[sheet_addr(anim_def[s], nxt[3:0])];
  endfunction

  function automatic safs_pkg::out_t anim_step(safs_pkg::in_t it);
    safs_pkg::out_t r;
    int unsigned id;
    int unsigned a;
    bit          found;
    r = '0;
    case (it.cmd)
      safs_pkg::CmdDefine: begin
        a = sheet_addr(it.def_id, it.frame_index);
        sheet_row[a]   = it.frame_row;
        sheet_col[a]   = it.frame_column;
        frame_ticks[a] = it.frame_duration;
        def_len[it.def_id] = (it.frame_total > safs_pkg::FramesPerDef) ?
                             5'(safs_pkg::FramesPerDef) : it.frame_total;
      end
      safs_pkg::CmdCreate: begin
        if (def_len[it.def_id] == 0) begin
          r.status = safs_pkg::StBadDef;
        end else begin
          id = anims_used;
          found = 1'b0;
          for (int unsigned i = 0; i < anims_used; i++) begin
            if (!found && !anim_live[i]) begin
              id = i;
              found = 1'b1;
            end
          end
          if (!found && anims_used >= safs_pkg::Slots) begin
            r.status = safs_pkg::StFull;
          end else begin
            if (!found) anims_used++;
            anim_def[id]   = it.def_id;
            anim_loop[id]  = it.loop_flag;
            anim_live[id]  = 1'b1;
            anim_frame[id] = '0;
            anim_ticks[id] = 0;
            r.slot_out = id[3:0];
          end
        end
      end
      safs_pkg::CmdDestroy: begin
        if (it.slot_id >= anims_used) r.status = safs_pkg::StBadSlt;
        else anim_live[it.slot_id] = 1'b0;
      end
      safs_pkg::CmdTick: begin
        for (int unsigned i = 0; i < anims_used; i++) age_anim(i, int'(it.tick_delta));
      end
      safs_pkg::CmdGet: begin
        if (it.slot_id >= anims_used) begin
          r.status = safs_pkg::StBadSlt;
        end else begin
          a = sheet_addr(anim_def[it.slot_id], anim_frame[it.slot_id]);
          r.slot_out      = it.slot_id;
          r.current_frame = anim_frame[it.slot_id];
          r.row_out       = sheet_row[a];
          r.column_out    = sheet_col[a];
          r.time_left     = anim_ticks[it.slot_id][16:0];
          r.active_out    = anim_live[it.slot_id];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic safs_pkg::in_t blank_cmd(logic [2:0] c);
    safs_pkg::in_t it;
    it = '0;
    it.cmd            = c;
    it.def_id         = 3'($urandom);
    it.frame_index    = 4'($urandom);
    it.frame_total    = 5'($urandom_range(1, 16));
    it.frame_row      = 8'($urandom);
    it.frame_column   = 8'($urandom);
    it.frame_duration = 16'($urandom);
    it.slot_id        = 4'($urandom);
    it.loop_flag      = 1'($urandom);
    it.tick_delta     = 16'($urandom);
    return it;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_cmd(safs_pkg::in_t it);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    results_due.push_back(anim_step(it));
  endtask

  task automatic define_frame(logic [2:0] d, logic [3:0] f, logic [4:0] n,
                              logic [7:0] row, logic [7:0] col, logic [15:0] dur);
    safs_pkg::in_t it;
    it = blank_cmd(safs_pkg::CmdDefine);
    it.def_id = d;
    it.frame_index = f;
    it.frame_total = n;
    it.frame_row = row;
    it.frame_column = col;
    it.frame_duration = dur;
    send_cmd(it);
  endtask

  task automatic slot_cmd(logic [2:0] c, logic [3:0] s);
    safs_pkg::in_t it;
    it = blank_cmd(c);
    it.slot_id = s;
    send_cmd(it);
  endtask

  task automatic create_anim(logic [2:0] d, logic lp);
    safs_pkg::in_t it;
    it = blank_cmd(safs_pkg::CmdCreate);
    it.def_id = d;
    it.loop_flag = lp;
    send_cmd(it);
  endtask

  task automatic tick_by(logic [15:0] dt);
    safs_pkg::in_t it;
    it = blank_cmd(safs_pkg::CmdTick);
    it.tick_delta = dt;
    send_cmd(it);
  endtask

  task automatic test_directed();
    define_frame(3'd0, 4'd0, 5'd3, 8'h00, 8'hFF, 16'd0);
    define_frame(3'd0, 4'd1, 5'd3, 8'hFF, 8'h00, 16'hFFFF);
    define_frame(3'd0, 4'd2, 5'd3, 8'h5A, 8'hA5, 16'd5);
    define_frame(3'd1, 4'd0, 5'd1, 8'h12, 8'h34, 16'd2);
    create_anim(3'd2, 1'b1);
    slot_cmd(safs_pkg::CmdGet, 4'd0);
    slot_cmd(safs_pkg::CmdDestroy, 4'd15);
    create_anim(3'd0, 1'b1);
    create_anim(3'd1, 1'b0);
    slot_cmd(safs_pkg::CmdGet, 4'd0);
    tick_by(16'd0);
    slot_cmd(safs_pkg::CmdGet, 4'd0);
    slot_cmd(safs_pkg::CmdGet, 4'd1);
    tick_by(16'hFFFF);
    slot_cmd(safs_pkg::CmdGet, 4'd0);
    tick_by(16'd3);
    slot_cmd(safs_pkg::CmdGet, 4'd0);
    define_frame(3'd1, 4'd0, 5'd0, 8'h77, 8'h88, 16'd1);
    tick_by(16'd5);
    slot_cmd(safs_pkg::CmdGet, 4'd1);
    slot_cmd(safs_pkg::CmdDestroy, 4'd0);
    slot_cmd(safs_pkg::CmdGet, 4'd0);
    create_anim(3'd0, 1'b0);
    tick_by(16'hFFFF);
    tick_by(16'hFFFF);
    slot_cmd(safs_pkg::CmdGet, 4'd0);
    send_cmd(blank_cmd(CmdSpareLo));
    send_cmd(blank_cmd(CmdSpareHi));
  endtask

  // write every frame so later reads never hit an empty entry
  task automatic test_fill_sheet();
    for (int d = 0; d < safs_pkg::Definitions; d++) begin
      for (int f = 0; f < safs_pkg::FramesPerDef; f++) begin
        define_frame(d[2:0], f[3:0], 5'($urandom_range(1, 31)), 8'($urandom),
                     8'($urandom), 16'($urandom_range(0, 40)));
      end
    end
  endtask

  task automatic test_table_full();
    quiet = 1'b1;
    for (int i = 0; i < 18; i++) create_anim(3'($urandom_range(0, 7)), 1'($urandom));
    slot_cmd(safs_pkg::CmdGet, 4'd15);
    slot_cmd(safs_pkg::CmdDestroy, 4'd7);
    create_anim(3'd3, 1'b1);
    quiet = 1'b0;
  endtask

  task automatic random_cmd();
    safs_pkg::in_t it;
    int unsigned   r;
    r = $urandom_range(0, 99);
    it = blank_cmd(safs_pkg::CmdGet);
    if (r < 12) begin
      it.cmd = safs_pkg::CmdDefine;
      if ($urandom_range(0, 9) == 0) it.frame_total = 5'($urandom_range(0, 31));
      else it.frame_total = 5'($urandom_range(1, 16));
      if ($urandom_range(0, 1)) it.frame_duration = 16'($urandom_range(0, 50));
    end else if (r < 27) begin
      it.cmd = safs_pkg::CmdCreate;
    end else if (r < 37) begin
      it.cmd = safs_pkg::CmdDestroy;
    end else if (r < 62) begin
      it.cmd = safs_pkg::CmdTick;
      if ($urandom_range(0, 3) != 0) it.tick_delta = 16'($urandom_range(0, 30));
    end else if (r < 96) begin
      it.cmd = safs_pkg::CmdGet;
    end else begin
      it.cmd = 3'($urandom_range(CmdSpareLo, CmdSpareHi));
    end
    send_cmd(it);
  endtask

  task automatic test_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 200 == 0) quiet = ~quiet;
      random_cmd();
    end
    quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    quiet = 1'b1;
    for (int i = 0; i < 30; i++) random_cmd();
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      stall_left <= LongHold;
      res_if.ready <= 1'b0;
    end else if (quiet || $urandom_range(0, 99) < 75) begin
      res_if.ready <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      res_if.ready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    safs_pkg::out_t got;
    safs_pkg::out_t want;
    got = res_if.data;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status || got.slot_out !== want.slot_out ||
            got.current_frame !== want.current_frame || got.row_out !== want.row_out ||
            got.column_out !== want.column_out || got.time_left !== want.time_left ||
            got.active_out !== want.active_out) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    errors = 0;
    quiet = 1'b0;
    hold_request = 1'b0;
    for (int i = 0; i < safs_pkg::Definitions; i++) def_len[i] = '0;
    for (int i = 0; i < safs_pkg::Slots; i++) begin
      anim_def[i] = '0;
      anim_loop[i] = 1'b0;
      anim_live[i] = 1'b0;
      anim_frame[i] = '0;
      anim_ticks[i] = 0;
    end
    anims_used = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_fill_sheet();
    test_table_full();
    test_random(700);
    test_backpressure();
    test_random(700);
    cmd_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
